@@ hw/rtl/pfacl_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package pfacl_pkg;

    // Field widths
    localparam int ADDR_W       = 32;
    localparam int LEN_W        = 6;
    localparam int OUT_IDX_W    = 8;
    localparam int CMD_W        = 2;
    localparam int S_TDATA_W    = 40;
    localparam int M_TDATA_W    = 16;

    // Table depth default
    localparam int MAX_RULES_DEF = 256;

    // Longest meaningful prefix
    localparam logic [LEN_W-1:0] PLEN_MAX = LEN_W'(ADDR_W);

    // Commands carried on tuser; the fourth code leaves the table unchanged
    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR = 2'd0,
        CMD_ADD   = 2'd1,
        CMD_QUERY = 2'd2
    } cmd_t;

    // One stored rule
    typedef struct packed {
        logic              action;
        logic [LEN_W-1:0]  length;
        logic [ADDR_W-1:0] prefix;
    } rule_t;

    localparam int RULE_W = $bits(rule_t);

    // Leading-ones mask for a prefix length of 0..32
    function automatic logic [ADDR_W-1:0] len_mask(input logic [LEN_W-1:0] len);
        logic [ADDR_W-1:0] m;
        if (len == '0) begin
            m = '0;
        end else begin
            m = {ADDR_W{1'b1}} << (PLEN_MAX - len);
        end
        return m;
    endfunction

    // Saturate a requested length to 32
    function automatic logic [LEN_W-1:0] len_sat(input logic [LEN_W-1:0] len);
        return (len > PLEN_MAX) ? PLEN_MAX : len;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/ipv4_prefix_first_match_acl.sv @@
`timescale 1ns / 1ps
`default_nettype none

// IPv4 first-match access-control list. Send clear, add or query items on the
// slave stream (command on s_tuser); every item returns exactly one result item.
// Clear and add go from acceptance straight to ST_DONE, which loads the result
// item. A query walks the rule table in insertion order through one compare
// unit fed by a rule RAM with one write port and one registered read port, one
// rule per cycle: the read address is issued in ST_SCAN, the RAM output
// register feeds the compare, and the first hit (its index is reported as
// rule_index) or the end of the n stored rules (at most MAX_RULES) moves to
// ST_DONE, which loads the result item. s_tready is low while an item is in
// progress and rises as its result item is loaded, so items never overlap;
// ST_DONE waits while the previous result item is still waiting on m_tready.
// Unmatched addresses are permitted; an add to a full table is dropped and flagged in status.
module ipv4_prefix_first_match_acl_core
    import pfacl_pkg::*;
#(
    parameter int MAX_RULES = MAX_RULES_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // [31:0] address, [37:32] prefix_len, [38] allow, [39] zero
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // [1:0] cmd
    input  wire logic [CMD_W-1:0]     s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // [0] status, [1] permit, [2] matched, [10:3] rule_index, [15:11] zero
    output logic [M_TDATA_W-1:0]      m_tdata
);

    localparam int IDX_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
    localparam int CNT_W = $clog2(MAX_RULES + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_RULES);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    rd_idx_reg, rd_idx_next;
    logic                cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]    cmp_idx_reg, cmp_idx_next;
    logic [ADDR_W-1:0]   qaddr_reg, qaddr_next;
    logic                res_status_reg, res_status_next;
    logic                res_permit_reg, res_permit_next;
    logic                res_matched_reg, res_matched_next;
    logic [OUT_IDX_W-1:0] res_index_reg, res_index_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    // Input unpacking
    logic [ADDR_W-1:0] in_addr;
    logic [LEN_W-1:0]  in_len;
    logic              in_allow;
    logic              in_accept;

    assign in_addr   = s_tdata[ADDR_W-1:0];
    assign in_len    = s_tdata[ADDR_W +: LEN_W];
    assign in_allow  = s_tdata[ADDR_W + LEN_W];
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;

    // Rule RAM
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    rule_t            ram_wdata;
    logic             ram_re;
    logic [IDX_W-1:0] ram_raddr;
    rule_t            ram_rdata;

    pfacl_rule_ram #(
        .DEPTH  (MAX_RULES),
        .ADDR_W (IDX_W),
        .DATA_W (RULE_W)
    ) u_rule_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Compare unit: one stored rule against the query address
    logic hit;
    assign hit = cmp_valid_reg &&
                 (((ram_rdata.prefix ^ qaddr_reg) & len_mask(ram_rdata.length)) == '0);

    // Scan issue
    logic issue;
    assign issue = (state_reg == ST_SCAN) && (rd_idx_reg < count_reg);

    assign ram_re    = issue;
    assign ram_raddr = rd_idx_reg[IDX_W-1:0];
    assign ram_waddr = count_reg[IDX_W-1:0];
    assign ram_wdata = '{action: in_allow, length: len_sat(in_len), prefix: in_addr};

    // Sequencer
    always_comb begin
        state_next       = state_reg;
        count_next       = count_reg;
        rd_idx_next      = rd_idx_reg;
        cmp_valid_next   = 1'b0;
        cmp_idx_next     = cmp_idx_reg;
        qaddr_next       = qaddr_reg;
        res_status_next  = res_status_reg;
        res_permit_next  = res_permit_reg;
        res_matched_next = res_matched_reg;
        res_index_next   = res_index_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_tdata_next     = m_tdata_reg;
        ram_we           = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    res_status_next  = 1'b0;
                    res_permit_next  = 1'b0;
                    res_matched_next = 1'b0;
                    res_index_next   = '0;
                    state_next       = ST_DONE;
                    unique case (s_tuser)
                        CMD_CLEAR: begin
                            count_next = '0;
                        end
                        CMD_ADD: begin
                            if (count_reg >= CNT_FULL) begin
                                res_status_next = 1'b1;
                            end else begin
                                ram_we     = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        CMD_QUERY: begin
                            qaddr_next      = in_addr;
                            rd_idx_next     = '0;
                            res_permit_next = 1'b1;
                            state_next      = ST_SCAN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (issue) begin
                    rd_idx_next    = rd_idx_reg + 1'b1;
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = rd_idx_reg[IDX_W-1:0];
                end
                if (hit) begin
                    res_permit_next  = ram_rdata.action;
                    res_matched_next = 1'b1;
                    res_index_next   = OUT_IDX_W'(cmp_idx_reg);
                    cmp_valid_next   = 1'b0;
                    state_next       = ST_DONE;
                end else if (!issue) begin
                    // table exhausted without a hit: default permit stands
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{(M_TDATA_W - OUT_IDX_W - 3){1'b0}}, res_index_reg,
                                     res_matched_reg, res_permit_reg, res_status_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cmp_valid_reg <= cmp_valid_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        rd_idx_reg      <= rd_idx_next;
        cmp_idx_reg     <= cmp_idx_next;
        qaddr_reg       <= qaddr_next;
        res_status_reg  <= res_status_next;
        res_permit_reg  <= res_permit_next;
        res_matched_reg <= res_matched_next;
        res_index_reg   <= res_index_next;
        m_tdata_reg     <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

@@ hw/rtl/pfacl_rule_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pfacl_rule_ram #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8,
    parameter int DATA_W = 39
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire
